// ===== rtl/cnrs_pkg.sv =====
package cnrs_pkg;

  // Value formats: x and the coefficients are VW-bit signed with FB fraction bits,
  // intermediates are IW-bit signed and saturate.
  localparam int VW        = 48;
  localparam int FB        = 32;
  localparam int IW        = 64;
  localparam int HALF      = IW / 2;
  localparam int PW        = 2 * IW;
  localparam int STEPS_W   = 8;
  localparam int OUTCOME_W = 2;
  localparam int DIV_STEPS = IW + FB;
  localparam int DCW       = $clog2(DIV_STEPS);

  typedef logic signed [IW-1:0] val_t;
  typedef logic        [IW-1:0] mag_t;
  typedef logic signed [VW-1:0] x_t;
  typedef logic        [2:0]    op_t;
  typedef logic        [2:0]    reg_idx_t;

  localparam val_t VAL_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(IW-1){1'b0}}};
  localparam x_t   X_MAX   = {1'b0, {(VW-1){1'b1}}};
  localparam x_t   X_MIN   = {1'b1, {(VW-1){1'b0}}};

  // Datapath operations
  localparam op_t OP_NONE      = 3'd0;
  localparam op_t OP_LOAD      = 3'd1;
  localparam op_t OP_ADD_SQ    = 3'd2;
  localparam op_t OP_ADD_LIN   = 3'd3;
  localparam op_t OP_ADD_CONST = 3'd4;
  localparam op_t OP_TRIPLE    = 3'd5;
  localparam op_t OP_ADD_2SQ   = 3'd6;
  localparam op_t OP_UPDATE    = 3'd7;

  // Configuration register indexes (byte address is 8 * index)
  localparam reg_idx_t REG_SQUARE   = 3'd0;
  localparam reg_idx_t REG_LINEAR   = 3'd1;
  localparam reg_idx_t REG_CONSTANT = 3'd2;
  localparam reg_idx_t REG_TOL      = 3'd3;
  localparam reg_idx_t REG_LIMIT    = 3'd4;

  // Result status codes
  localparam logic [OUTCOME_W-1:0] OUT_CONVERGED  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_LIMIT      = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_ZERO_DERIV = 2'd2;

  typedef struct packed {
    op_t  op;
    logic mul_start;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic f_ok;
    logic at_limit;
    logic df_zero;
  } sts_t;

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic [IW:0] s;
    s = {a[IW-1], a} + {b[IW-1], b};
    if (s[IW] != s[IW-1]) sat_add = s[IW] ? VAL_MIN : VAL_MAX;
    else sat_add = s[IW-1:0];
  endfunction

  function automatic val_t sat_neg(input val_t a);
    sat_neg = (a == VAL_MIN) ? VAL_MAX : -a;
  endfunction

  function automatic mag_t magn(input val_t v);
    magn = v[IW-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  // Signed value from sign and magnitude, saturated to IW bits
  function automatic val_t from_mag(input logic neg, input logic over, input mag_t m);
    if (neg) from_mag = (over || m[IW-1]) ? VAL_MIN : val_t'(-m);
    else from_mag = (over || m[IW-1]) ? VAL_MAX : val_t'(m);
  endfunction

  function automatic x_t clamp_vw(input val_t v);
    if (v[IW-1:VW-1] != {(IW-VW+1){v[IW-1]}}) clamp_vw = v[IW-1] ? X_MIN : X_MAX;
    else clamp_vw = v[VW-1:0];
  endfunction

endpackage

// ===== rtl/cnrs_mul.sv =====
// Serial fixed-point multiplier: four 32x32 partial products, one per cycle.
module cnrs_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cnrs_pkg::val_t   a,
  input  cnrs_pkg::val_t   b,
  output logic             done,
  output cnrs_pkg::val_t   prod
);

  localparam logic [2:0] MUL_LAST = 3'd4;

  cnrs_pkg::mag_t                 ua;
  cnrs_pkg::mag_t                 ub;
  logic                           neg;
  logic [2:0]                     cnt;
  logic                           busy;
  logic [cnrs_pkg::IW-1:0]        pp;
  logic [1:0]                     pp_sh;
  logic [cnrs_pkg::PW-1:0]        acc;
  logic [cnrs_pkg::PW-1:0]        addend;
  logic [cnrs_pkg::HALF-1:0]      a_half;
  logic [cnrs_pkg::HALF-1:0]      b_half;
  cnrs_pkg::mag_t                 r;
  logic                           over;

  assign a_half = cnt[1] ? ua[cnrs_pkg::IW-1:cnrs_pkg::HALF] : ua[cnrs_pkg::HALF-1:0];
  assign b_half = cnt[0] ? ub[cnrs_pkg::IW-1:cnrs_pkg::HALF] : ub[cnrs_pkg::HALF-1:0];

  always_comb begin
    case (pp_sh)
      2'd0:    addend = cnrs_pkg::PW'(pp);
      2'd1:    addend = cnrs_pkg::PW'(pp) << cnrs_pkg::HALF;
      2'd2:    addend = cnrs_pkg::PW'(pp) << cnrs_pkg::IW;
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= cnrs_pkg::magn(a);
      ub  <= cnrs_pkg::magn(b);
      neg <= a[cnrs_pkg::IW-1] ^ b[cnrs_pkg::IW-1];
      acc <= '0;
    end else if (busy) begin
      pp    <= a_half * b_half;
      pp_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
      if (cnt != 3'd0) acc <= acc + addend;
    end
  end

  // Drop the fraction bits; anything above the kept word is overflow
  assign r    = acc[cnrs_pkg::FB+cnrs_pkg::IW-1:cnrs_pkg::FB];
  assign over = |acc[cnrs_pkg::PW-1:cnrs_pkg::FB+cnrs_pkg::IW];
  assign prod = cnrs_pkg::from_mag(neg, over, r);

endmodule

// ===== rtl/cnrs_div.sv =====
// Restoring fixed-point divider, one quotient bit per cycle.
module cnrs_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cnrs_pkg::val_t   n,
  input  cnrs_pkg::val_t   d,
  output logic             done,
  output cnrs_pkg::val_t   quot
);

  cnrs_pkg::mag_t              num;
  cnrs_pkg::mag_t              ud;
  cnrs_pkg::mag_t              rem;
  cnrs_pkg::mag_t              q;
  logic                        over;
  logic                        neg;
  logic [cnrs_pkg::DCW-1:0]    cnt;
  logic                        busy;
  logic [cnrs_pkg::IW:0]       trial;
  logic [cnrs_pkg::IW:0]       diff;
  logic                        fits;

  // Dividend is |n| followed by FB zeros; bring in its top bit each cycle
  assign trial = {rem, num[cnrs_pkg::IW-1]};
  assign diff  = trial - {1'b0, ud};
  assign fits  = trial >= {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= cnrs_pkg::DCW'(cnrs_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - cnrs_pkg::DCW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= cnrs_pkg::magn(n);
      ud   <= cnrs_pkg::magn(d);
      rem  <= '0;
      q    <= '0;
      over <= 1'b0;
      neg  <= n[cnrs_pkg::IW-1] ^ d[cnrs_pkg::IW-1];
    end else if (busy) begin
      num  <= {num[cnrs_pkg::IW-2:0], 1'b0};
      rem  <= fits ? diff[cnrs_pkg::IW-1:0] : trial[cnrs_pkg::IW-1:0];
      q    <= {q[cnrs_pkg::IW-2:0], fits};
      over <= over | q[cnrs_pkg::IW-1];
    end
  end

  assign quot = cnrs_pkg::from_mag(neg, over, q);

endmodule

// ===== rtl/cnrs_dp.sv =====
// Newton datapath: x, working value, f(x), step count, shared mul and div units.
module cnrs_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cnrs_pkg::cmd_t                cmd,
  output cnrs_pkg::sts_t                sts,
  input  cnrs_pkg::x_t                  initial_guess,
  input  cnrs_pkg::x_t                  coef_square,
  input  cnrs_pkg::x_t                  coef_linear,
  input  cnrs_pkg::x_t                  coef_constant,
  input  logic [cnrs_pkg::VW-2:0]       tolerance,
  input  logic [cnrs_pkg::STEPS_W-1:0]  iteration_limit,
  output cnrs_pkg::x_t                  root,
  output logic [cnrs_pkg::STEPS_W-1:0]  steps_taken
);

  cnrs_pkg::x_t                   x;
  cnrs_pkg::val_t                 xs;
  cnrs_pkg::val_t                 sq;
  cnrs_pkg::val_t                 t;
  cnrs_pkg::val_t                 f;
  logic [cnrs_pkg::STEPS_W-1:0]   steps;
  logic                           mul_done;
  cnrs_pkg::val_t                 prod;
  logic                           div_done;
  cnrs_pkg::val_t                 quot;

  assign xs = cnrs_pkg::IW'(x);
  assign sq = cnrs_pkg::IW'(coef_square);

  cnrs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (t),
    .b     (xs),
    .done  (mul_done),
    .prod  (prod)
  );

  cnrs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .n     (f),
    .d     (t),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (mul_done) t <= prod;
    unique case (cmd.op)
      cnrs_pkg::OP_LOAD: begin
        x     <= initial_guess;
        steps <= '0;
      end
      cnrs_pkg::OP_ADD_SQ:    t <= cnrs_pkg::sat_add(xs, sq);
      cnrs_pkg::OP_ADD_LIN:   t <= cnrs_pkg::sat_add(t, cnrs_pkg::IW'(coef_linear));
      cnrs_pkg::OP_ADD_CONST: f <= cnrs_pkg::sat_add(t, cnrs_pkg::IW'(coef_constant));
      cnrs_pkg::OP_TRIPLE:    t <= cnrs_pkg::sat_add(cnrs_pkg::sat_add(xs, xs), xs);
      cnrs_pkg::OP_ADD_2SQ:   t <= cnrs_pkg::sat_add(t, cnrs_pkg::sat_add(sq, sq));
      cnrs_pkg::OP_UPDATE: begin
        x     <= cnrs_pkg::clamp_vw(cnrs_pkg::sat_add(xs, cnrs_pkg::sat_neg(quot)));
        steps <= steps + cnrs_pkg::STEPS_W'(1);
      end
      default: ;
    endcase
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.f_ok     = cnrs_pkg::magn(f) <= cnrs_pkg::mag_t'(tolerance);
  assign sts.at_limit = steps >= iteration_limit;
  assign sts.df_zero  = (t == '0);

  assign root        = x;
  assign steps_taken = steps;

  // A product lands in t; no other write to t may collide with it
  a_mul_no_op: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (cmd.op == cnrs_pkg::OP_NONE))
    else $error("product write collides with a datapath operation");

endmodule

// ===== rtl/cnrs_ctrl.sv =====
// Sequencer for one Newton solve: evaluate f, test, evaluate f', divide, update.
module cnrs_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cnrs_pkg::sts_t                   sts,
  input  logic                             out_free,
  output cnrs_pkg::cmd_t                   cmd,
  output logic                             finish,
  output logic [cnrs_pkg::OUTCOME_W-1:0]   outcome
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FADD   = 5'd1;
  localparam logic [4:0] S_FMUL1  = 5'd2;
  localparam logic [4:0] S_FW1    = 5'd3;
  localparam logic [4:0] S_FLIN   = 5'd4;
  localparam logic [4:0] S_FMUL2  = 5'd5;
  localparam logic [4:0] S_FW2    = 5'd6;
  localparam logic [4:0] S_FCONST = 5'd7;
  localparam logic [4:0] S_FTEST  = 5'd8;
  localparam logic [4:0] S_DFA    = 5'd9;
  localparam logic [4:0] S_DFB    = 5'd10;
  localparam logic [4:0] S_DMUL   = 5'd11;
  localparam logic [4:0] S_DW     = 5'd12;
  localparam logic [4:0] S_DLIN   = 5'd13;
  localparam logic [4:0] S_DTEST  = 5'd14;
  localparam logic [4:0] S_DIVW   = 5'd15;
  localparam logic [4:0] S_UPD    = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  logic [4:0]                        state;
  logic [4:0]                        state_next;
  logic [cnrs_pkg::OUTCOME_W-1:0]    outcome_next;

  always_comb begin
    state_next   = state;
    outcome_next = outcome;
    cmd          = '0;
    finish       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = cnrs_pkg::OP_LOAD;
          state_next = S_FADD;
        end
      end
      S_FADD: begin
        cmd.op     = cnrs_pkg::OP_ADD_SQ;
        state_next = S_FMUL1;
      end
      S_FMUL1: begin
        cmd.mul_start = 1'b1;
        state_next    = S_FW1;
      end
      S_FW1:   if (sts.mul_done) state_next = S_FLIN;
      S_FLIN: begin
        cmd.op     = cnrs_pkg::OP_ADD_LIN;
        state_next = S_FMUL2;
      end
      S_FMUL2: begin
        cmd.mul_start = 1'b1;
        state_next    = S_FW2;
      end
      S_FW2:   if (sts.mul_done) state_next = S_FCONST;
      S_FCONST: begin
        cmd.op     = cnrs_pkg::OP_ADD_CONST;
        state_next = S_FTEST;
      end
      S_FTEST: begin
        if (sts.f_ok) begin
          outcome_next = cnrs_pkg::OUT_CONVERGED;
          state_next   = S_OUT;
        end else if (sts.at_limit) begin
          outcome_next = cnrs_pkg::OUT_LIMIT;
          state_next   = S_OUT;
        end else begin
          state_next = S_DFA;
        end
      end
      S_DFA: begin
        cmd.op     = cnrs_pkg::OP_TRIPLE;
        state_next = S_DFB;
      end
      S_DFB: begin
        cmd.op     = cnrs_pkg::OP_ADD_2SQ;
        state_next = S_DMUL;
      end
      S_DMUL: begin
        cmd.mul_start = 1'b1;
        state_next    = S_DW;
      end
      S_DW:    if (sts.mul_done) state_next = S_DLIN;
      S_DLIN: begin
        cmd.op     = cnrs_pkg::OP_ADD_LIN;
        state_next = S_DTEST;
      end
      S_DTEST: begin
        if (sts.df_zero) begin
          outcome_next = cnrs_pkg::OUT_ZERO_DERIV;
          state_next   = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVW;
        end
      end
      S_DIVW:  if (sts.div_done) state_next = S_UPD;
      S_UPD: begin
        cmd.op     = cnrs_pkg::OP_UPDATE;
        state_next = S_FADD;
      end
      S_OUT: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      outcome <= cnrs_pkg::OUT_CONVERGED;
    end else begin
      state   <= state_next;
      outcome <= outcome_next;
    end
  end

  // Hold off requests while reset is applied
  assign in_ready = (state == S_IDLE) && !rst;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.df_zero)
    else $error("division started with a zero derivative");

  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |-> (state == S_FW1 || state == S_FW2 || state == S_DW))
    else $error("product arrived outside a wait state");

endmodule

// ===== rtl/cubic_newton_root_solver.sv =====
// Newton-Raphson root finder for the monic cubic x^3 + a2*x^2 + a1*x + a0.
// Input stream (s_t*): one request per item, the initial guess in signed Q16.32.
// Output stream (m_t*): one result per request: final x, number of updates, and
// a status on m_tuser (converged, iteration limit reached, zero derivative).
// APB port: coefficients, tolerance on |f(x)| and the iteration limit, at byte
// addresses 0, 8, 16, 24, 32; write only while no request is in flight.
// Each solve evaluates and tests f(x); each Newton update evaluates f, f' and
// one quotient. The quotient comes from the shared serial divider, one bit a
// cycle over 64 + fraction-bits steps (96 at Q16.32); each multiply is four
// 32x32 partial products.
// Throughput: one request at a time; the next is taken once the current result
// sits in the output register, so a result waiting on m_tready does not hold up
// the next solve, but a second finished result waits until the first is taken.
// Reset (rst, synchronous) empties the output register, returns the sequencer
// to idle and loads the default cubic (-16, 73, -90), tolerance 1e-5, limit 64.
module cubic_newton_root_solver (
  input  logic         clk,
  input  logic         rst,
  // Input: [47:0] initial_guess
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,
  // Output: [47:0] root, [55:48] steps_taken
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,
  // Output: [1:0] outcome
  output logic [1:0]   m_tuser,
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int VW     = cnrs_pkg::VW;
  localparam int IW     = cnrs_pkg::IW;
  localparam int OUT_W  = ((VW + cnrs_pkg::STEPS_W + 7) / 8) * 8;
  localparam int APB_W  = 64;

  // Reset values: integers moved to the fixed-point grid and clamped to VW bits
  localparam logic [IW:0] NEG_LIM = (IW+1)'(1) << (VW - 1);
  localparam logic [IW:0] MAG_SQ  = (IW+1)'(16) << cnrs_pkg::FB;
  localparam logic [IW:0] MAG_LIN = (IW+1)'(73) << cnrs_pkg::FB;
  localparam logic [IW:0] MAG_CON = (IW+1)'(90) << cnrs_pkg::FB;
  localparam cnrs_pkg::x_t RST_SQUARE =
    (MAG_SQ >= NEG_LIM) ? cnrs_pkg::X_MIN : VW'((IW+1)'(0) - MAG_SQ);
  localparam cnrs_pkg::x_t RST_LINEAR =
    (MAG_LIN >= NEG_LIM) ? cnrs_pkg::X_MAX : VW'(MAG_LIN);
  localparam cnrs_pkg::x_t RST_CONSTANT =
    (MAG_CON >= NEG_LIM) ? cnrs_pkg::X_MIN : VW'((IW+1)'(0) - MAG_CON);
  localparam logic [VW-2:0] RST_TOL =
    (VW-1)'(((64'd1 << cnrs_pkg::FB) + 64'd50000) / 64'd100000);
  localparam logic [cnrs_pkg::STEPS_W-1:0] RST_LIMIT = 8'd64;

  cnrs_pkg::x_t                        coef_square;
  cnrs_pkg::x_t                        coef_linear;
  cnrs_pkg::x_t                        coef_constant;
  logic [VW-2:0]                       tolerance;
  logic [cnrs_pkg::STEPS_W-1:0]        iteration_limit;

  cnrs_pkg::cmd_t                      cmd;
  cnrs_pkg::sts_t                      sts;
  logic                                finish;
  logic [cnrs_pkg::OUTCOME_W-1:0]      outcome;
  logic                                out_free;
  cnrs_pkg::x_t                        root;
  logic [cnrs_pkg::STEPS_W-1:0]        steps_taken;

  logic                                out_vld;
  cnrs_pkg::x_t                        out_root;
  logic [cnrs_pkg::STEPS_W-1:0]        out_steps;
  logic [cnrs_pkg::OUTCOME_W-1:0]      out_outcome;

  logic                                wr_en;

  // Configuration registers: written in the access phase
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_square     <= RST_SQUARE;
      coef_linear     <= RST_LINEAR;
      coef_constant   <= RST_CONSTANT;
      tolerance       <= RST_TOL;
      iteration_limit <= RST_LIMIT;
    end else if (wr_en) begin
      unique case (paddr[5:3])
        cnrs_pkg::REG_SQUARE:   coef_square     <= pwdata[VW-1:0];
        cnrs_pkg::REG_LINEAR:   coef_linear     <= pwdata[VW-1:0];
        cnrs_pkg::REG_CONSTANT: coef_constant   <= pwdata[VW-1:0];
        cnrs_pkg::REG_TOL:      tolerance       <= pwdata[VW-2:0];
        cnrs_pkg::REG_LIMIT:    iteration_limit <= pwdata[cnrs_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      cnrs_pkg::REG_SQUARE:   prdata = APB_W'(coef_square);
      cnrs_pkg::REG_LINEAR:   prdata = APB_W'(coef_linear);
      cnrs_pkg::REG_CONSTANT: prdata = APB_W'(coef_constant);
      cnrs_pkg::REG_TOL:      prdata = APB_W'(tolerance);
      cnrs_pkg::REG_LIMIT:    prdata = APB_W'(iteration_limit);
      default:                prdata = '0;
    endcase
  end

  cnrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .out_free (out_free),
    .cmd      (cmd),
    .finish   (finish),
    .outcome  (outcome)
  );

  cnrs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .initial_guess   (s_tdata[VW-1:0]),
    .coef_square     (coef_square),
    .coef_linear     (coef_linear),
    .coef_constant   (coef_constant),
    .tolerance       (tolerance),
    .iteration_limit (iteration_limit),
    .root            (root),
    .steps_taken     (steps_taken)
  );

  // Output register: hold the result until the receiver takes it
  assign out_free = !out_vld || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (finish) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_root    <= root;
      out_steps   <= steps_taken;
      out_outcome <= outcome;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = OUT_W'({out_steps, out_root});
  assign m_tuser  = out_outcome;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    finish |-> (!out_vld || m_tready))
    else $error("result overwrote one not yet taken");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request taken while one is in flight");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Wide signed intermediate, matching the 64-bit saturating datapath
  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    cnrs_pkg::x_t root;
    logic [7:0]   steps;
    logic [1:0]   outcome;
  } solution_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  // Index past the last configuration register
  localparam cnrs_pkg::reg_idx_t REG_UNUSED = 3'd5;

  localparam wide_t W_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam wide_t W_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [63:0] TOL_DEFAULT = 64'd42950;
  localparam logic [63:0] TOL_MAX     = 64'h0000_7FFF_FFFF_FFFF;
  localparam int          HOLD_CYCLES = 3000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [5:0]  paddr    = '0;
  logic [63:0] pwdata   = '0;
  logic [63:0] prdata;
  logic        pready;

  cubic_newton_root_solver DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial forever #5 clk = ~clk;

  // Shadow copy of the configuration registers, reset values of the block
  wide_t       cf_sq    = 64'hFFFF_FFF0_0000_0000;
  wide_t       cf_lin   = 64'h0000_0049_0000_0000;
  wide_t       cf_const = 64'hFFFF_FFA6_0000_0000;
  logic [46:0] cf_tol   = 47'd42950;
  logic [7:0]  cf_lim   = 8'd64;

  cnrs_pkg::x_t guesses_pending[$];
  solution_t    solutions_due[$];
  solution_t    want;

  int       errors = 0;
  bit       req_fire = 1'b0;
  int       burst_left = 1;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       rx_phase = 0;
  int       hold_left = 0;
  bit       hold_asked = 1'b0;
  longint   cycles = 0;
  longint   cycle_budget = 100000;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the solver: saturating 64-bit adds, products and
  // quotients on magnitudes with truncation toward zero.
  // ---------------------------------------------------------------------------
  function automatic wide_t clip_sum(wide_t a, wide_t b);
    wide_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? W_MIN : W_MAX;
    return s;
  endfunction

  function automatic wide_t neg_sat(wide_t a);
    return (a == W_MIN) ? W_MAX : -a;
  endfunction

  function automatic logic [63:0] abs_of(wide_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic wide_t signed_from(bit neg, bit over, logic [63:0] m);
    if (neg) return (over || m[63]) ? W_MIN : wide_t'(-m);
    return (over || m[63]) ? W_MAX : wide_t'(m);
  endfunction

  function automatic wide_t fx_mul(wide_t a, wide_t b);
    logic [127:0] p;
    p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
    return signed_from(a[63] ^ b[63], p[127:96] != 0, p[95:32]);
  endfunction

  function automatic wide_t fx_div(wide_t n, wide_t d);
    logic [127:0] num;
    logic [127:0] quo;
    num = {64'd0, abs_of(n)} << 32;
    quo = num / {64'd0, abs_of(d)};
    return signed_from(n[63] ^ d[63], quo[127:64] != 0, quo[63:0]);
  endfunction

  function automatic cnrs_pkg::x_t clamp48(wide_t v);
    if (v > wide_t'(cnrs_pkg::X_MAX)) return cnrs_pkg::X_MAX;
    if (v < wide_t'(cnrs_pkg::X_MIN)) return cnrs_pkg::X_MIN;
    return v[47:0];
  endfunction

  // Horner forms of f and f'
  function automatic wide_t poly_at(wide_t x);
    wide_t t;
    t = clip_sum(x, cf_sq);
    t = clip_sum(fx_mul(t, x), cf_lin);
    return clip_sum(fx_mul(t, x), cf_const);
  endfunction

  function automatic wide_t slope_at(wide_t x);
    wide_t t;
    t = clip_sum(clip_sum(x, x), x);
    t = clip_sum(t, clip_sum(cf_sq, cf_sq));
    return clip_sum(fx_mul(t, x), cf_lin);
  endfunction

  // Full Newton solve of one guess under the current shadow configuration
  function automatic solution_t newton_solve(cnrs_pkg::x_t guess);
    solution_t s;
    wide_t     x;
    wide_t     fx;
    wide_t     dx;
    bit        done;
    x = wide_t'(guess);
    s.steps = 8'd0;
    s.outcome = cnrs_pkg::OUT_CONVERGED;
    done = 1'b0;
    while (!done) begin
      fx = poly_at(x);
      if (abs_of(fx) <= {17'd0, cf_tol}) begin
        s.outcome = cnrs_pkg::OUT_CONVERGED;
        done = 1'b1;
      end else if (s.steps >= cf_lim) begin
        s.outcome = cnrs_pkg::OUT_LIMIT;
        done = 1'b1;
      end else begin
        dx = slope_at(x);
        if (dx == 0) begin
          s.outcome = cnrs_pkg::OUT_ZERO_DERIV;
          done = 1'b1;
        end else begin
          x = wide_t'(clamp48(clip_sum(x, neg_sat(fx_div(fx, dx)))));
          s.steps = s.steps + 8'd1;
        end
      end
    end
    s.root = x[47:0];
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic wide_t q_of(int whole);
    return wide_t'(whole) <<< 32;
  endfunction

  // Random Q16.32 value with integer part in [lo, hi] and a random fraction
  function automatic wide_t rand_fixed(int lo, int hi);
    int whole;
    whole = lo + int'($urandom_range(0, hi - lo));
    return (wide_t'(whole) <<< 32) | wide_t'({32'd0, $urandom});
  endfunction

  // Mostly guesses near the roots; narrow drops full-range and extreme guesses,
  // which crawl for hundreds of steps under saturation
  function automatic cnrs_pkg::x_t rand_guess(bit narrow);
    int pick;
    pick = narrow ? int'($urandom_range(0, 74)) : int'($urandom_range(0, 99));
    if (pick < 55) return cnrs_pkg::x_t'(rand_fixed(-6, 14));
    if (pick < 75) return cnrs_pkg::x_t'(rand_fixed(-128, 127));
    if (pick < 90) return cnrs_pkg::x_t'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: return cnrs_pkg::X_MAX;
      1: return cnrs_pkg::X_MIN;
      2: return cnrs_pkg::x_t'(0);
      default: return cnrs_pkg::x_t'(-1);
    endcase
  endfunction

  // Queue one request; grow the run budget by its slowest possible solve
  task automatic queue_guess(input cnrs_pkg::x_t g);
    guesses_pending.push_back(g);
    cycle_budget += (longint'(cf_lim) + 1) * 170 + 200;
  endtask

  // Hold until every queued request has been taken and answered
  task automatic wait_idle();
    while (guesses_pending.size() != 0 || s_tvalid || solutions_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // APB write, only with the solver idle; mirror it into the shadow copy
  task automatic write_reg(input cnrs_pkg::reg_idx_t idx, input logic [63:0] value);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cnrs_pkg::REG_SQUARE:   cf_sq    = {{16{value[47]}}, value[47:0]};
      cnrs_pkg::REG_LINEAR:   cf_lin   = {{16{value[47]}}, value[47:0]};
      cnrs_pkg::REG_CONSTANT: cf_const = {{16{value[47]}}, value[47:0]};
      cnrs_pkg::REG_TOL:      cf_tol   = value[46:0];
      cnrs_pkg::REG_LIMIT:    cf_lim   = value[7:0];
      default: ;
    endcase
    cycle_budget += 100;
  endtask

  // Cubic with three integer roots in [-8, 8], so Newton has somewhere to go
  task automatic pick_root_cubic();
    int r1;
    int r2;
    int r3;
    r1 = int'($urandom_range(0, 16)) - 8;
    r2 = int'($urandom_range(0, 16)) - 8;
    r3 = int'($urandom_range(0, 16)) - 8;
    write_reg(cnrs_pkg::REG_SQUARE, q_of(-(r1 + r2 + r3)));
    write_reg(cnrs_pkg::REG_LINEAR, q_of(r1 * r2 + r1 * r3 + r2 * r3));
    write_reg(cnrs_pkg::REG_CONSTANT, q_of(-(r1 * r2 * r3)));
  endtask

  task automatic run_random(input int count, input bit narrow);
    repeat (count) queue_guess(rand_guess(narrow));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer requests from the pending queue in bursts with gaps between.
  // A request stays on the bus until the rising edge that takes it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!s_tvalid || req_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (guesses_pending.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= guesses_pending.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          // Back-to-back bursts now and then, mostly short gaps, a few long ones
          if ($urandom_range(0, 99) < 35) gap_left = 0;
          else if ($urandom_range(0, 99) < 85) gap_left = $urandom_range(1, 5);
          else gap_left = $urandom_range(10, 40);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch between stall patterns at random intervals; on a
  // hold request drop m_tready for a long stretch so the solver backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_phase++;
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    if (hold_asked) begin
      hold_left  = HOLD_CYCLES;
      hold_asked = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= (rx_phase % 5 != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict each taken request, check each taken result against the
  // oldest prediction field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    req_fire = !rst && s_tvalid && s_tready;
    if (req_fire) solutions_due.push_back(newton_solve(s_tdata));
    if (!rst && m_tvalid && m_tready) begin
      if (solutions_due.size() == 0) begin
        $error("result with no request outstanding: root %h", m_tdata[47:0]);
        errors++;
      end else begin
        want = solutions_due.pop_front();
        if (m_tdata[47:0] !== want.root) begin
          $error("root: expected %h, actual %h", want.root, m_tdata[47:0]);
          errors++;
        end
        if (m_tdata[55:48] !== want.steps) begin
          $error("steps_taken: expected %0d, actual %0d", want.steps, m_tdata[55:48]);
          errors++;
        end
        if (m_tuser !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, m_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog, several times the slowest legal run of what has been queued
  always @(posedge clk) begin
    cycles++;
    if (cycles > 3 * cycle_budget) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset cubic (x-2)(x-5)(x-9): guesses near each root, then the extremes
    queue_guess(cnrs_pkg::x_t'(48'h0002_1999_9999));
    queue_guess(cnrs_pkg::x_t'(48'h0005_4000_0000));
    queue_guess(cnrs_pkg::x_t'(48'h0008_C000_0000));
    queue_guess(cnrs_pkg::x_t'(0));
    queue_guess(cnrs_pkg::X_MAX);
    queue_guess(cnrs_pkg::X_MIN);
    queue_guess(cnrs_pkg::x_t'(1));
    queue_guess(cnrs_pkg::x_t'(-1));

    // x^3 + 1: f' vanishes at zero, so the guess 0 stops with no update
    write_reg(cnrs_pkg::REG_SQUARE, 64'd0);
    write_reg(cnrs_pkg::REG_LINEAR, 64'd0);
    write_reg(cnrs_pkg::REG_CONSTANT, q_of(1));
    write_reg(cnrs_pkg::REG_LIMIT, 64'd10);
    queue_guess(cnrs_pkg::x_t'(0));
    queue_guess(cnrs_pkg::x_t'(48'h0001_0000_0000));

    // x^3 - 2x + 2 from 0 cycles between 0 and 1 until the largest limit runs out
    write_reg(cnrs_pkg::REG_LINEAR, q_of(-2));
    write_reg(cnrs_pkg::REG_CONSTANT, q_of(2));
    write_reg(cnrs_pkg::REG_LIMIT, 64'd255);
    queue_guess(cnrs_pkg::x_t'(0));

    // Zero limit: an exact root still converges, anything else gives up at once
    write_reg(cnrs_pkg::REG_SQUARE, q_of(-16));
    write_reg(cnrs_pkg::REG_LINEAR, q_of(73));
    write_reg(cnrs_pkg::REG_CONSTANT, q_of(-90));
    write_reg(cnrs_pkg::REG_LIMIT, 64'd0);
    queue_guess(cnrs_pkg::x_t'(48'h0002_0000_0000));
    queue_guess(cnrs_pkg::x_t'(48'h0003_0000_0000));

    // Widest tolerance with a single allowed step
    write_reg(cnrs_pkg::REG_TOL, TOL_MAX);
    write_reg(cnrs_pkg::REG_LIMIT, 64'd1);
    queue_guess(cnrs_pkg::x_t'(0));
    queue_guess(cnrs_pkg::X_MAX);

    // Extreme coefficients and zero tolerance: large guesses saturate the intermediates
    write_reg(cnrs_pkg::REG_SQUARE, wide_t'(cnrs_pkg::X_MAX));
    write_reg(cnrs_pkg::REG_LINEAR, wide_t'(cnrs_pkg::X_MIN));
    write_reg(cnrs_pkg::REG_CONSTANT, wide_t'(cnrs_pkg::X_MAX));
    write_reg(cnrs_pkg::REG_TOL, 64'd0);
    write_reg(cnrs_pkg::REG_LIMIT, 64'd4);
    queue_guess(cnrs_pkg::X_MAX);
    queue_guess(cnrs_pkg::X_MIN);
    queue_guess(cnrs_pkg::x_t'(1));
    queue_guess(cnrs_pkg::x_t'(-1));

    // A write past the last register must change nothing
    write_reg(cnrs_pkg::REG_TOL, TOL_DEFAULT);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_guess(cnrs_pkg::x_t'(0));

    // Random phase: reset cubic, short limits
    write_reg(cnrs_pkg::REG_SQUARE, q_of(-16));
    write_reg(cnrs_pkg::REG_LINEAR, q_of(73));
    write_reg(cnrs_pkg::REG_CONSTANT, q_of(-90));
    write_reg(cnrs_pkg::REG_LIMIT, 64'($urandom_range(3, 8)));
    run_random(225, 1'b0);

    // Random phase: random moderate coefficients
    write_reg(cnrs_pkg::REG_SQUARE, rand_fixed(-32, 31));
    write_reg(cnrs_pkg::REG_LINEAR, rand_fixed(-128, 127));
    write_reg(cnrs_pkg::REG_CONSTANT, rand_fixed(-512, 511));
    write_reg(cnrs_pkg::REG_TOL, 64'($urandom_range(0, 1 << 24)));
    write_reg(cnrs_pkg::REG_LIMIT, 64'd6);
    run_random(225, 1'b0);

    // Random phase: full-range coefficients and tolerance
    write_reg(cnrs_pkg::REG_SQUARE, wide_t'(cnrs_pkg::x_t'({$urandom, $urandom})));
    write_reg(cnrs_pkg::REG_LINEAR, wide_t'(cnrs_pkg::x_t'({$urandom, $urandom})));
    write_reg(cnrs_pkg::REG_CONSTANT, wide_t'(cnrs_pkg::x_t'({$urandom, $urandom})));
    write_reg(cnrs_pkg::REG_TOL, {17'd0, 47'({$urandom, $urandom})});
    write_reg(cnrs_pkg::REG_LIMIT, 64'($urandom_range(1, 8)));
    run_random(225, 1'b0);

    // Random phase: cubic with integer roots
    pick_root_cubic();
    write_reg(cnrs_pkg::REG_TOL, 64'($urandom_range(0, 1 << 20)));
    write_reg(cnrs_pkg::REG_LIMIT, 64'd8);
    run_random(225, 1'b0);

    // Random phase: zero tolerance, so only exact roots converge
    pick_root_cubic();
    write_reg(cnrs_pkg::REG_TOL, 64'd0);
    write_reg(cnrs_pkg::REG_LIMIT, 64'd3);
    run_random(225, 1'b0);

    // Random phase: widest tolerance and largest limit; fast solves back up
    // behind a long receiver hold-off and stall the input
    pick_root_cubic();
    write_reg(cnrs_pkg::REG_TOL, TOL_MAX);
    write_reg(cnrs_pkg::REG_LIMIT, 64'd255);
    run_random(225, 1'b1);
    cycle_budget += HOLD_CYCLES;
    @(posedge clk);
    hold_asked = 1'b1;

    wait_idle();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
